// ===== hdl/prt_pkg.sv =====
package prt_pkg;

    localparam int SEQ_BITS           = 32;
    localparam int PAYLOAD_FIELD_BITS = 32;
    localparam int DEF_TABLE_DEPTH    = 16;
    localparam int DEF_PAYLOAD_BITS   = 32;

    localparam logic [SEQ_BITS-1:0] SEQ_RESTART     = 32'd2;
    localparam logic [SEQ_BITS-1:0] SEQ_STEP        = 32'd2;
    // last accepted number at or above this restarts the count at SEQ_RESTART
    localparam logic [SEQ_BITS-1:0] SEQ_WRAP_LIMIT  = 32'hFFFF_FFFD;

    typedef enum logic [1:0] {
        OP_ADD      = 2'd0,
        OP_COMPLETE = 2'd1,
        OP_QUERY    = 2'd2,
        OP_RESERVED = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_MISMATCH  = 2'd1,
        STATUS_NOT_FOUND = 2'd2,
        STATUS_FULL      = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SEARCH_RD,
        ST_SEARCH_CMP,
        ST_COMPACT,
        ST_APPEND,
        ST_RESP
    } state_t;

    typedef struct packed {
        status_t                       status;
        logic                          pending;
        logic [PAYLOAD_FIELD_BITS-1:0] found_payload;
    } result_t;

endpackage

// ===== hdl/prt_mem.sv =====
module prt_mem import prt_pkg::*; #(
    parameter int DEPTH = DEF_TABLE_DEPTH,
    parameter int AW    = 4,
    parameter int WIDTH = 65
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/prt_ctrl.sv =====
module prt_ctrl import prt_pkg::*; #(
    parameter int TABLE_DEPTH  = DEF_TABLE_DEPTH,
    parameter int PAYLOAD_BITS = DEF_PAYLOAD_BITS,
    parameter int AW           = 4,
    parameter int MW           = 65
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_opcode,
    input  logic [SEQ_BITS-1:0]           s_seq,
    input  logic [PAYLOAD_FIELD_BITS-1:0] s_payload,
    output logic                          res_valid,
    input  logic                          res_ready,
    output result_t                       res,
    output logic                          mem_wr_en,
    output logic [AW-1:0]                 mem_wr_addr,
    output logic [MW-1:0]                 mem_wr_data,
    output logic                          mem_rd_en,
    output logic [AW-1:0]                 mem_rd_addr,
    input  logic [MW-1:0]                 mem_rd_data
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int SB = (PAYLOAD_BITS < PAYLOAD_FIELD_BITS) ? PAYLOAD_BITS : PAYLOAD_FIELD_BITS;
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    // ring position of an offset from a base slot
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                              input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = (CW+1)'(base) + (CW+1)'(off);
        if (sum >= (CW+1)'(TABLE_DEPTH)) begin
            sum = sum - (CW+1)'(TABLE_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    state_t              state_reg, state_next;
    opcode_t             op_reg, op_next;
    logic [SEQ_BITS-1:0] seq_reg, seq_next;
    logic [SB-1:0]       pay_reg, pay_next;
    logic [AW-1:0]       head_reg, head_next;
    logic [CW-1:0]       span_reg, span_next;
    logic [CW-1:0]       live_count_reg, live_count_next;
    logic [SEQ_BITS-1:0] last_reg, last_next;
    logic [CW-1:0]       lo_reg, lo_next;
    logic [CW-1:0]       hi_reg, hi_next;
    logic [CW-1:0]       mid_reg, mid_next;
    logic [CW-1:0]       idx_reg, idx_next;
    logic [CW-1:0]       out_reg, out_next;
    logic                cvld_reg, cvld_next;
    result_t             res_reg, res_next;

    logic                rd_live;
    logic [SEQ_BITS-1:0] rd_seq;
    logic [SB-1:0]       rd_pay;
    logic [SEQ_BITS-1:0] exp_seq;
    logic [CW:0]         mid_sum;
    logic [CW-1:0]       search_mid;

    assign rd_live    = mem_rd_data[MW-1];
    assign rd_seq     = mem_rd_data[SB +: SEQ_BITS];
    assign rd_pay     = mem_rd_data[SB-1:0];
    assign exp_seq    = (last_reg < SEQ_WRAP_LIMIT) ? last_reg + SEQ_STEP : SEQ_RESTART;
    assign mid_sum    = (CW+1)'(lo_reg) + (CW+1)'(hi_reg) - (CW+1)'(1);
    assign search_mid = mid_sum[CW:1];
    assign res        = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            head_reg       <= '0;
            span_reg       <= '0;
            live_count_reg <= '0;
            last_reg       <= '0;
            cvld_reg       <= 1'b0;
        end else begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            span_reg       <= span_next;
            live_count_reg <= live_count_next;
            last_reg       <= last_next;
            cvld_reg       <= cvld_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg  <= op_next;
        seq_reg <= seq_next;
        pay_reg <= pay_next;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        mid_reg <= mid_next;
        idx_reg <= idx_next;
        out_reg <= out_next;
        res_reg <= res_next;
    end

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        seq_next        = seq_reg;
        pay_next        = pay_reg;
        head_next       = head_reg;
        span_next       = span_reg;
        live_count_next = live_count_reg;
        last_next       = last_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        idx_next        = idx_reg;
        out_next        = out_reg;
        cvld_next       = cvld_reg;
        res_next        = res_reg;
        s_ready         = 1'b0;
        res_valid       = 1'b0;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = '0;
        mem_wr_data     = '0;
        mem_rd_en       = 1'b0;
        mem_rd_addr     = '0;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    op_next    = opcode_t'(s_opcode);
                    seq_next   = s_seq;
                    pay_next   = s_payload[SB-1:0];
                    state_next = ST_DECODE;
                end
            end

            ST_DECODE: begin
                res_next   = '{status: STATUS_NOT_FOUND, pending: 1'b0, found_payload: '0};
                state_next = ST_RESP;
                unique case (op_reg) inside
                    OP_ADD: begin
                        if (seq_reg != exp_seq) begin
                            res_next.status = STATUS_MISMATCH;
                        end else begin
                            last_next = seq_reg;
                            if (live_count_reg >= DEPTH_C) begin
                                res_next.status = STATUS_FULL;
                            end else if (span_reg >= DEPTH_C) begin
                                idx_next   = '0;
                                out_next   = '0;
                                cvld_next  = 1'b0;
                                state_next = ST_COMPACT;
                            end else begin
                                state_next = ST_APPEND;
                            end
                        end
                    end
                    OP_COMPLETE, OP_QUERY: begin
                        if (live_count_reg != '0) begin
                            lo_next    = '0;
                            hi_next    = span_reg;
                            state_next = ST_SEARCH_RD;
                        end
                    end
                    default: begin
                        state_next = ST_RESP;
                    end
                endcase
            end

            ST_SEARCH_RD: begin
                if (lo_reg < hi_reg) begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = slot_of(head_reg, search_mid);
                    mid_next    = search_mid;
                    state_next  = ST_SEARCH_CMP;
                end else begin
                    state_next = ST_RESP;
                end
            end

            ST_SEARCH_CMP: begin
                if (rd_seq < seq_reg) begin
                    lo_next    = mid_reg + ONE_C;
                    state_next = ST_SEARCH_RD;
                end else if (rd_seq > seq_reg) begin
                    hi_next    = mid_reg;
                    state_next = ST_SEARCH_RD;
                end else begin
                    // a hole with a matching number ends the search as a miss
                    state_next = ST_RESP;
                    if (rd_live) begin
                        res_next.status        = STATUS_OK;
                        res_next.pending       = 1'b1;
                        res_next.found_payload = PAYLOAD_FIELD_BITS'(rd_pay);
                        if (op_reg == OP_COMPLETE) begin
                            mem_wr_en       = 1'b1;
                            mem_wr_addr     = slot_of(head_reg, mid_reg);
                            mem_wr_data     = {1'b0, rd_seq, rd_pay};
                            live_count_next = live_count_reg - ONE_C;
                            if (mid_reg == '0) begin
                                head_next = slot_of(head_reg, ONE_C);
                                span_next = span_reg - ONE_C;
                            end else if (mid_reg + ONE_C == span_reg) begin
                                span_next = span_reg - ONE_C;
                            end
                        end
                    end
                end
            end

            ST_COMPACT: begin
                // write back the entry read last cycle if it is still live
                if (cvld_reg && rd_live) begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = slot_of(head_reg, out_reg);
                    mem_wr_data = {1'b1, rd_seq, rd_pay};
                    out_next    = out_reg + ONE_C;
                end
                if (idx_reg < span_reg) begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = slot_of(head_reg, idx_reg);
                    idx_next    = idx_reg + ONE_C;
                    cvld_next   = 1'b1;
                end else begin
                    cvld_next = 1'b0;
                    if (!cvld_reg) begin
                        span_next  = out_reg;
                        state_next = ST_APPEND;
                    end
                end
            end

            ST_APPEND: begin
                mem_wr_en       = 1'b1;
                mem_wr_addr     = slot_of(head_reg, span_reg);
                mem_wr_data     = {1'b1, seq_reg, pay_reg};
                span_next       = span_reg + ONE_C;
                live_count_next = live_count_reg + ONE_C;
                res_next.status = STATUS_OK;
                state_next      = ST_RESP;
            end

            ST_RESP: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        live_count_reg <= span_reg)
        else $error("live count exceeds span");

    assert property (@(posedge aclk) disable iff (!aresetn)
        span_reg <= DEPTH_C)
        else $error("span exceeds table depth");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_wr_en && mem_rd_en && (mem_wr_addr == mem_rd_addr)))
        else $error("read and write hit the same slot");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COMPACT) |-> (out_reg <= idx_reg))
        else $error("compaction write passed its read pointer");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_APPEND) |-> (span_reg < DEPTH_C))
        else $error("append into an exhausted span");

endmodule

// ===== hdl/pending_request_tracker_top.sv =====
// Pending request tracker: keeps up to TABLE_DEPTH outstanding requests in a
// ring held in one synchronous memory, ordered by sequence number. Add accepts
// only the next expected number (last accepted plus 2, restarting at 2 near
// the top of the 32-bit range); complete and query binary-search the span.
// One request is worked at a time. When the ring span is exhausted and holes
// remain, add first compacts the ring. Complete and query make at most
// floor(log2(TABLE_DEPTH)) + 1 search probes, each probe being one read of
// the memory port followed by one compare. Results sit in an output
// register, so a new request is taken while the previous result waits.
module pending_request_tracker_top import prt_pkg::*; #(
    parameter int TABLE_DEPTH  = DEF_TABLE_DEPTH,
    parameter int PAYLOAD_BITS = DEF_PAYLOAD_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_opcode,
    input  logic [SEQ_BITS-1:0]           s_seq,
    input  logic [PAYLOAD_FIELD_BITS-1:0] s_payload,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_status,
    output logic                          m_pending,
    output logic [PAYLOAD_FIELD_BITS-1:0] m_found_payload
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int SB = (PAYLOAD_BITS < PAYLOAD_FIELD_BITS) ? PAYLOAD_BITS : PAYLOAD_FIELD_BITS;
    localparam int MW = 1 + SEQ_BITS + SB;

    logic          res_valid;
    logic          res_ready;
    result_t       res;
    logic          mem_wr_en;
    logic [AW-1:0] mem_wr_addr;
    logic [MW-1:0] mem_wr_data;
    logic          mem_rd_en;
    logic [AW-1:0] mem_rd_addr;
    logic [MW-1:0] mem_rd_data;

    logic          m_valid_reg;
    result_t       m_res_reg;

    prt_ctrl #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .PAYLOAD_BITS (PAYLOAD_BITS),
        .AW           (AW),
        .MW           (MW)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_opcode    (s_opcode),
        .s_seq       (s_seq),
        .s_payload   (s_payload),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    prt_mem #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW),
        .WIDTH (MW)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // output register: load when empty or being drained
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_res_reg <= res;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_res_reg.status;
    assign m_pending       = m_res_reg.pending;
    assign m_found_payload = m_res_reg.found_payload;

endmodule

// ===== tb/sv/tb_pending_request_tracker_top.sv =====
`timescale 1ns / 1ps

module tb_pending_request_tracker_top;
    import prt_pkg::*;

    localparam int DEPTH        = DEF_TABLE_DEPTH;
    localparam int CLK_PERIOD   = 20;
    localparam int DRAIN_CYCLES = 40;
    localparam int LIMIT_CYCLES = 500_000;

    logic                          aclk            = 1'b0;
    logic                          aresetn         = 1'b0;
    logic                          s_valid         = 1'b0;
    logic                          s_ready;
    logic [1:0]                    s_opcode        = OP_ADD;
    logic [SEQ_BITS-1:0]           s_seq           = '0;
    logic [PAYLOAD_FIELD_BITS-1:0] s_payload       = '0;
    logic                          m_valid;
    logic                          m_ready         = 1'b0;
    logic [1:0]                    m_status;
    logic                          m_pending;
    logic [PAYLOAD_FIELD_BITS-1:0] m_found_payload;

    pending_request_tracker_top #(
        .TABLE_DEPTH  (DEPTH),
        .PAYLOAD_BITS (DEF_PAYLOAD_BITS)
    ) u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_seq           (s_seq),
        .s_payload       (s_payload),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_pending       (m_pending),
        .m_found_payload (m_found_payload)
    );

    // shadow copy of the ring
    logic [SEQ_BITS-1:0]           tbl_seq  [DEPTH];
    logic [PAYLOAD_FIELD_BITS-1:0] tbl_pay  [DEPTH];
    bit                            tbl_live [DEPTH];
    int                            head_idx;
    int                            span_cnt;
    int                            live_cnt;
    logic [SEQ_BITS-1:0]           accepted_seq;

    result_t expected_responses [$];
    result_t rx_expected;

    bit idle_enable;
    int rx_hold_req;
    int hold_left;
    int stall_left;

    int error_cnt;
    int checked_cnt;
    int n_add;
    int n_complete;
    int n_query;
    int n_reserved;
    int full_cnt;
    int compact_cnt;
    int hit_cnt;
    int hole_cnt;

    initial begin
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("tb: failure");
        $finish;
    end

    function automatic int slot_at(int off);
        return (head_idx + off) % DEPTH;
    endfunction

    function automatic logic [SEQ_BITS-1:0] seq_after(logic [SEQ_BITS-1:0] cur);
        return (cur < SEQ_WRAP_LIMIT) ? cur + SEQ_STEP : SEQ_RESTART;
    endfunction

    function automatic result_t predict_response(logic [1:0] op, logic [SEQ_BITS-1:0] seq,
                                                 logic [PAYLOAD_FIELD_BITS-1:0] pay);
        result_t r;
        int      lo;
        int      hi;
        int      mid;
        int      off;
        int      outp;
        int      s;
        int      d;
        bit      searching;
        r.status        = STATUS_NOT_FOUND;
        r.pending       = 1'b0;
        r.found_payload = '0;
        case (op) inside
            OP_ADD: begin
                if (seq != seq_after(accepted_seq)) begin
                    r.status = STATUS_MISMATCH;
                end else begin
                    accepted_seq = seq;
                    if (live_cnt >= DEPTH) begin
                        r.status = STATUS_FULL;
                        full_cnt++;
                    end else begin
                        if (span_cnt >= DEPTH) begin
                            // squeeze live entries to the head, clear the rest
                            outp = 0;
                            for (int i = 0; i < span_cnt; i++) begin
                                s = slot_at(i);
                                if (tbl_live[s]) begin
                                    d = slot_at(outp);
                                    tbl_seq[d]  = tbl_seq[s];
                                    tbl_pay[d]  = tbl_pay[s];
                                    tbl_live[d] = 1'b1;
                                    outp++;
                                end
                            end
                            for (int i = outp; i < span_cnt; i++) begin
                                d = slot_at(i);
                                tbl_live[d] = 1'b0;
                                tbl_seq[d]  = '0;
                                tbl_pay[d]  = '0;
                            end
                            span_cnt = outp;
                            compact_cnt++;
                        end
                        s = slot_at(span_cnt);
                        tbl_seq[s]  = seq;
                        tbl_pay[s]  = pay;
                        tbl_live[s] = 1'b1;
                        span_cnt++;
                        live_cnt++;
                        r.status = STATUS_OK;
                    end
                end
            end
            OP_COMPLETE, OP_QUERY: begin
                off       = -1;
                lo        = 0;
                hi        = span_cnt - 1;
                searching = (live_cnt != 0);
                while (searching && lo <= hi) begin
                    mid = (lo + hi) / 2;
                    s   = slot_at(mid);
                    if (tbl_seq[s] < seq) begin
                        lo = mid + 1;
                    end else if (tbl_seq[s] > seq) begin
                        hi = mid - 1;
                    end else begin
                        // a hole with this number is a miss
                        if (tbl_live[s]) off = mid;
                        else hole_cnt++;
                        searching = 1'b0;
                    end
                end
                if (off >= 0) begin
                    s               = slot_at(off);
                    r.status        = STATUS_OK;
                    r.pending       = 1'b1;
                    r.found_payload = tbl_pay[s];
                    hit_cnt++;
                    if (op == OP_COMPLETE) begin
                        tbl_live[s] = 1'b0;
                        live_cnt--;
                        if (off == 0) begin
                            head_idx = slot_at(1);
                            span_cnt--;
                        end else if (off + 1 == span_cnt) begin
                            span_cnt--;
                        end
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // pick a sequence number from the span: a live entry or a hole
    function automatic logic [SEQ_BITS-1:0] pick_span_seq(bit want_live);
        int idx [$];
        int s;
        for (int i = 0; i < span_cnt; i++) begin
            s = slot_at(i);
            if (tbl_live[s] == want_live) idx.push_back(s);
        end
        if (idx.size() == 0) return $urandom;
        return tbl_seq[idx[$urandom_range(0, idx.size() - 1)]];
    endfunction

    task automatic send_request(logic [1:0] op, logic [SEQ_BITS-1:0] seq,
                                logic [PAYLOAD_FIELD_BITS-1:0] pay);
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_opcode  <= op;
        s_seq     <= seq;
        s_payload <= pay;
        do @(posedge aclk); while (!s_ready);
        expected_responses.push_back(predict_response(op, seq, pay));
        case (op)
            OP_ADD:      n_add++;
            OP_COMPLETE: n_complete++;
            OP_QUERY:    n_query++;
            default:     n_reserved++;
        endcase
    endtask

    task automatic send_next_add();
        send_request(OP_ADD, seq_after(accepted_seq), $urandom);
    endtask

    task automatic test_basic_ops();
        send_request(OP_QUERY, 32'd2, 32'd0);
        send_request(OP_COMPLETE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(OP_ADD, 32'd0, 32'h1234_5678);
        send_request(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(OP_ADD, 32'd2, 32'hFFFF_FFFF);
        send_request(OP_ADD, 32'd4, 32'h0000_0000);
        send_request(OP_ADD, 32'd6, $urandom);
        send_request(OP_ADD, 32'd8, 32'h5555_AAAA);
        send_request(OP_QUERY, 32'd4, 32'hFFFF_FFFF);
        send_request(OP_QUERY, 32'd5, 32'd0);
        send_request(OP_QUERY, 32'd0, 32'd0);
        send_request(OP_QUERY, 32'hFFFF_FFFF, 32'd0);
        send_request(OP_COMPLETE, 32'd4, 32'd0);
        send_request(OP_QUERY, 32'd4, 32'd0);
        send_request(OP_COMPLETE, 32'd4, 32'd0);
        send_request(OP_COMPLETE, 32'd2, 32'd0);
        send_request(OP_COMPLETE, 32'd8, 32'd0);
        send_request(OP_RESERVED, 32'd6, 32'hFFFF_FFFF);
        send_request(OP_QUERY, 32'd6, 32'd0);
        send_request(OP_COMPLETE, 32'd6, 32'd0);
        send_request(OP_QUERY, 32'd6, 32'd0);
    endtask

    task automatic test_fill_and_compact();
        while (live_cnt < DEPTH) send_next_add();
        send_next_add();
        send_next_add();
        send_request(OP_ADD, accepted_seq, $urandom);
        repeat (4) send_request(OP_COMPLETE, pick_span_seq(1'b1), $urandom);
        send_request(OP_QUERY, pick_span_seq(1'b0), $urandom);
        // span is usually exhausted here: the next add then compacts first
        repeat (3) send_next_add();
        send_request(OP_QUERY, pick_span_seq(1'b1), $urandom);
        while (live_cnt > 0) send_request(OP_COMPLETE, pick_span_seq(1'b1), $urandom);
    endtask

    task automatic test_random(int count);
        bit filling;
        int roll;
        filling = 1'b1;
        for (int i = 0; i < count; i++) begin
            if (i % 40 == 39) filling = ~filling;
            roll = $urandom_range(0, 99);
            if (!filling) roll = (roll < 50) ? roll * 2 / 5 + 60 : roll - 50;
            if (roll < 50) begin
                send_next_add();
            end else if (roll < 58) begin
                send_request(OP_ADD, roll[0] ? $urandom : accepted_seq, $urandom);
            end else if (roll < 78) begin
                send_request(OP_COMPLETE, pick_span_seq(1'b1), $urandom);
            end else if (roll < 87) begin
                send_request(OP_QUERY, pick_span_seq(1'b1), $urandom);
            end else if (roll < 92) begin
                send_request(2'($urandom_range(OP_COMPLETE, OP_QUERY)), pick_span_seq(1'b0),
                             $urandom);
            end else if (roll < 98) begin
                send_request(2'($urandom_range(OP_COMPLETE, OP_QUERY)), $urandom, $urandom);
            end else begin
                send_request(OP_RESERVED, $urandom, $urandom);
            end
        end
    endtask

    task automatic test_backpressure();
        // hold the result side while requests keep coming
        rx_hold_req = 80;
        for (int i = 0; i < 24; i++) begin
            if (i % 3 == 2) send_request(OP_QUERY, pick_span_seq(1'b1), $urandom);
            else send_next_add();
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                checked_cnt++;
                if (expected_responses.size() == 0) begin
                    if (error_cnt < 10)
                        $display("unexpected result: status %0d pending %0d payload %h",
                                 m_status, m_pending, m_found_payload);
                    error_cnt++;
                end else begin
                    rx_expected = expected_responses.pop_front();
                    if (m_status !== rx_expected.status || m_pending !== rx_expected.pending ||
                        m_found_payload !== rx_expected.found_payload) begin
                        if (error_cnt < 10)
                            $display({"mismatch: exp status %0d pending %0d payload %h,",
                                      " got %0d %0d %h"},
                                     rx_expected.status, rx_expected.pending,
                                     rx_expected.found_payload, m_status, m_pending,
                                     m_found_payload);
                        error_cnt++;
                    end
                end
            end
            if (rx_hold_req > 0) begin
                hold_left   = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (idle_enable && $urandom_range(0, 4) == 0) begin
                m_ready    <= 1'b0;
                stall_left = $urandom_range(0, 3);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        for (int i = 0; i < DEPTH; i++) begin
            tbl_seq[i]  = '0;
            tbl_pay[i]  = '0;
            tbl_live[i] = 1'b0;
        end
        head_idx     = 0;
        span_cnt     = 0;
        live_cnt     = 0;
        accepted_seq = '0;
        idle_enable  = 1'b1;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_basic_ops();
        test_fill_and_compact();
        test_random(1000);
        test_backpressure();
        idle_enable = 1'b0;
        test_random(100);

        s_valid <= 1'b0;
        while (expected_responses.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("ran %0d adds (%0d full, %0d compactions), %0d completes, %0d queries,",
                 n_add, full_cnt, compact_cnt, n_complete, n_query);
        $display("%0d reserved; checked %0d results: %0d hits, %0d hole misses, %0d errors",
                 n_reserved, checked_cnt, hit_cnt, hole_cnt, error_cnt);
        if (error_cnt == 0 && expected_responses.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
